// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/diss_pkg.sv =====
// Package: field widths, timing constants and register indexes of the sleep scheduler.
package diss_pkg;

   // field widths
   localparam int CFG_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int TOTAL_W    = 24;
   localparam int DAYS_W     = 8;
   localparam int HOURS_W    = 5;
   localparam int MINUTES_W  = 6;
   localparam int SECONDS_W  = 6;

   // timing constants, seconds
   localparam int unsigned FLOOR_S   = 10;
   localparam int unsigned MIN_S     = 15;
   localparam int unsigned MIN_RTC_S = 60;
   localparam int unsigned DAY_S     = 86400;
   localparam int unsigned HOUR_S    = 3600;
   localparam int unsigned MINUTE_S  = 60;

   // day = 2^7 * 675, split for the reciprocal divide
   localparam int unsigned DAY_SHIFT = 7;
   localparam int unsigned DAY_ODD   = DAY_S >> DAY_SHIFT;

   // hour = 2^4 * 225; hour and minute reciprocals rounded up, exact over their ranges
   localparam int unsigned HOUR_SHIFT     = 4;
   localparam int unsigned HOUR_ODD       = HOUR_S >> HOUR_SHIFT;
   localparam int unsigned HOUR_RCP_SHIFT = 20;
   localparam int unsigned MIN_RCP_SHIFT  = 17;

   localparam int unsigned HOURS_PER_DAY   = DAY_S / HOUR_S;
   localparam int unsigned MINUTES_PER_HOUR = HOUR_S / MINUTE_S;

   // remainder widths: seconds within a day, within an hour
   localparam int DAY_REM_W  = 17;
   localparam int HOUR_REM_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEARTBEAT_INTERVAL = 2'd0,
      CSR_WORK_INTERVAL      = 2'd1,
      CSR_RTC_PRESENT        = 2'd2
   } csr_index_type;

endpackage

// ===== hw/rtl/diss_if.sv =====
// Channel interfaces: request, response and register write.
interface diss_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface diss_rsp_if;
   import diss_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TOTAL_W-1:0]   wait_total;
   logic [DAYS_W-1:0]    wait_days;
   logic [HOURS_W-1:0]   wait_hours;
   logic [MINUTES_W-1:0] wait_minutes;
   logic [SECONDS_W-1:0] wait_seconds;
   logic                 heartbeat_due;

   modport source (output valid, output wait_total, output wait_days, output wait_hours,
                   output wait_minutes, output wait_seconds, output heartbeat_due,
                   input ready);
   modport sink   (input valid, input wait_total, input wait_days, input wait_hours,
                   input wait_minutes, input wait_seconds, input heartbeat_due,
                   output ready);
endinterface

interface diss_csr_if;
   import diss_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dual_interval_sleep_scheduler.sv =====
// Top level of the dual interval sleep scheduler: countdown update and wait breakdown pipeline.
//
//   channel  dir  handshake       payload
//   req_if   in   valid/ready     restart
//   rsp_if   out  valid/ready     wait_total, wait_days/hours/minutes/seconds, heartbeat_due
//   csr_if   in   valid/ready     index (register), data
//
// One request per cycle while the response side is ready; each request gives one response
// after passing stages s1 to s5. The rate is set by the countdown update,
// which reads and writes both timers in the cycle of the request transfer.
// Reset (synchronous) restores the register defaults, zeroes both timers and empties
// the pipeline. A stalled response holds only the stages behind it: bubbles close up,
// so requests keep transferring until all five stages are full.
`include "assert_macros.svh"

module dual_interval_sleep_scheduler #(
   parameter int TIMER_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   diss_req_if.sink      req_if,
   diss_rsp_if.source    rsp_if,
   diss_csr_if.sink      csr_if
);
   import diss_pkg::*;

   // widths derived from the timer size
   localparam int WW  = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;  // common compare width
   localparam int W7  = TIMER_BITS - DAY_SHIFT;                      // wait >> 7
   localparam int DQW = TIMER_BITS - 16;                             // day quotient
   localparam int PW  = W7 + DQW;                                    // reciprocal product
   localparam int DXW = (DQW > DAYS_W) ? DQW : DAYS_W;
   localparam int HPW = HOUR_RCP_SHIFT + HOURS_W;                    // hour product
   localparam int MPW = MIN_RCP_SHIFT + MINUTES_W;                   // minute product

   localparam logic [WW-1:0]         TMAX_W    = WW'((64'(1) << TIMER_BITS) - 64'(1));
   localparam logic [TIMER_BITS-1:0] FLOOR_T   = TIMER_BITS'(FLOOR_S);
   localparam logic [TIMER_BITS-1:0] DAY_T     = TIMER_BITS'(DAY_S);
   localparam logic [DQW-1:0]        DAY_RECIP = DQW'((64'(1) << W7) / DAY_ODD);
   localparam logic [HPW-1:0]        HOUR_RECIP =
      HPW'((64'(1) << HOUR_RCP_SHIFT) / HOUR_ODD + 64'(1));
   localparam logic [MPW-1:0]        MIN_RECIP  =
      MPW'((64'(1) << MIN_RCP_SHIFT) / MINUTE_S + 64'(1));

   // ---------------------------------------------------------------
   // configuration registers; writes always taken
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] beat_int_ff;
   logic [CFG_W-1:0] work_int_ff;
   logic             rtc_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_int_ff <= CFG_W'(900);
         work_int_ff <= CFG_W'(60);
         rtc_ff      <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_HEARTBEAT_INTERVAL: beat_int_ff <= csr_if.data;
            CSR_WORK_INTERVAL:      work_int_ff <= csr_if.data;
            CSR_RTC_PRESENT:        rtc_ff      <= csr_if.data[0];
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   // saturate a 24-bit interval into the timer width
   function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [CFG_W-1:0] v);
      logic [WW-1:0] ext;
      logic [WW-1:0] res;
      ext = WW'(v);
      res = (ext > TMAX_W) ? TMAX_W : ext;
      return res[TIMER_BITS-1:0];
   endfunction

   // clamped reload values
   logic [CFG_W-1:0]      beat_min;
   logic [CFG_W-1:0]      beat_lim;
   logic [CFG_W-1:0]      work_lim;
   logic [TIMER_BITS-1:0] beat_reload;
   logic [TIMER_BITS-1:0] work_reload;

   assign beat_min    = rtc_ff ? CFG_W'(MIN_RTC_S) : CFG_W'(MIN_S);
   assign beat_lim    = (beat_int_ff < beat_min) ? beat_min : beat_int_ff;
   assign work_lim    = (work_int_ff < CFG_W'(MIN_S)) ? CFG_W'(MIN_S) : work_int_ff;
   assign beat_reload = sat_timer(beat_lim);
   assign work_reload = sat_timer(work_lim);

   // ---------------------------------------------------------------
   // pipeline handshake: each stage moves when the next has room
   // ---------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
   logic req_fire;

   assign s5_rdy       = !s5_vld_ff || rsp_if.ready;
   assign s4_rdy       = !s4_vld_ff || s5_rdy;
   assign s3_rdy       = !s3_vld_ff || s4_rdy;
   assign s2_rdy       = !s2_vld_ff || s3_rdy;
   assign s1_rdy       = !s1_vld_ff || s2_rdy;
   assign req_if.ready = s1_rdy;
   assign req_fire     = req_if.valid && s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= req_if.valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 0: countdown update on the request transfer
   // ---------------------------------------------------------------
   logic [TIMER_BITS-1:0] beat_ff, work_ff;
   logic [TIMER_BITS-1:0] beat_in, work_in;
   logic [TIMER_BITS-1:0] beat_cur, work_cur;
   logic [TIMER_BITS-1:0] wait_raw, larger, diff, shrunk;
   logic [TIMER_BITS-1:0] s1_wait_in;
   logic                  beat_wins;

   always_comb begin
      // restart reloads both timers before the pick
      beat_cur   = req_if.restart ? beat_reload : beat_ff;
      work_cur   = req_if.restart ? work_reload : work_ff;
      beat_wins  = beat_cur < work_cur;  // tie goes to work
      wait_raw   = beat_wins ? beat_cur : work_cur;
      larger     = beat_wins ? work_cur : beat_cur;
      diff       = larger - wait_raw;
      shrunk     = (diff > FLOOR_T) ? diff : FLOOR_T;
      beat_in    = beat_wins ? beat_reload : shrunk;
      work_in    = beat_wins ? shrunk : work_reload;
      s1_wait_in = (wait_raw < FLOOR_T) ? FLOOR_T : wait_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
         work_ff <= '0;
      end else if (req_fire) begin
         beat_ff <= beat_in;
         work_ff <= work_in;
      end
   end

   logic [TIMER_BITS-1:0] s1_wait_ff;
   logic                  s1_beat_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_wait_ff <= s1_wait_in;
         s1_beat_ff <= beat_wins;
      end
   end

   // ---------------------------------------------------------------
   // stage 1 -> 2: day quotient estimate, (wait >> 7) * floor(2^W7 / 675) >> W7
   // estimate is exact or one low
   // ---------------------------------------------------------------
   logic [PW-1:0]         s2_prod;
   logic [DQW-1:0]        s2_qest_in;
   logic [DQW-1:0]        s2_qest_ff;
   logic [TIMER_BITS-1:0] s2_wait_ff;
   logic                  s2_beat_ff;

   assign s2_prod    = PW'(s1_wait_ff[TIMER_BITS-1:DAY_SHIFT]) * PW'(DAY_RECIP);
   assign s2_qest_in = s2_prod[PW-1:W7];

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_vld_ff) begin
         s2_qest_ff <= s2_qest_in;
         s2_wait_ff <= s1_wait_ff;
         s2_beat_ff <= s1_beat_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 2 -> 3: correct the day quotient, seconds within the day
   // ---------------------------------------------------------------
   logic [TIMER_BITS-1:0] s3_rd_raw;
   logic                  s3_fix;
   logic [DQW-1:0]        s3_days_in;
   logic [DAY_REM_W-1:0]  s3_rd_in;
   logic [WW-1:0]         s3_wait_ext;
   logic [TOTAL_W-1:0]    s3_total_in;

   logic [DQW-1:0]        s3_days_ff;
   logic [DAY_REM_W-1:0]  s3_rd_ff;
   logic [TOTAL_W-1:0]    s3_total_ff;
   logic                  s3_beat_ff;

   always_comb begin
      s3_rd_raw   = s2_wait_ff - TIMER_BITS'(s2_qest_ff) * DAY_T;
      s3_fix      = s3_rd_raw >= DAY_T;
      s3_days_in  = s2_qest_ff + DQW'(s3_fix);
      s3_rd_in    = DAY_REM_W'(s3_fix ? s3_rd_raw - DAY_T : s3_rd_raw);
      s3_wait_ext = WW'(s2_wait_ff);
      s3_total_in = s3_wait_ext[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_vld_ff) begin
         s3_days_ff  <= s3_days_in;
         s3_rd_ff    <= s3_rd_in;
         s3_total_ff <= s3_total_in;
         s3_beat_ff  <= s2_beat_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3 -> 4: hours, (rem >> 4) * ceil(2^20 / 225) >> 20
   // exact for any remainder inside one day
   // ---------------------------------------------------------------
   logic [HPW-1:0]        s4_hprod;
   logic [HOURS_W-1:0]    s4_hours_in;
   logic [HOUR_REM_W-1:0] s4_rh_in;

   logic [DQW-1:0]        s4_days_ff;
   logic [HOURS_W-1:0]    s4_hours_ff;
   logic [HOUR_REM_W-1:0] s4_rh_ff;
   logic [TOTAL_W-1:0]    s4_total_ff;
   logic                  s4_beat_ff;

   always_comb begin
      logic [DAY_REM_W-1:0] h_base;
      s4_hprod    = HPW'(s3_rd_ff[DAY_REM_W-1:HOUR_SHIFT]) * HOUR_RECIP;
      s4_hours_in = s4_hprod[HPW-1:HOUR_RCP_SHIFT];
      h_base      = DAY_REM_W'(s4_hours_in) * DAY_REM_W'(HOUR_S);
      s4_rh_in    = HOUR_REM_W'(s3_rd_ff - h_base);
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_vld_ff) begin
         s4_days_ff  <= s3_days_ff;
         s4_hours_ff <= s4_hours_in;
         s4_rh_ff    <= s4_rh_in;
         s4_total_ff <= s3_total_ff;
         s4_beat_ff  <= s3_beat_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4 -> 5: minutes by rem * ceil(2^17 / 60) >> 17, seconds, response register
   // ---------------------------------------------------------------
   logic [MPW-1:0]        s5_mprod;
   logic [MINUTES_W-1:0]  s5_min_in;
   logic [SECONDS_W-1:0]  s5_sec_in;
   logic [DXW-1:0]        s5_days_ext;

   logic [TOTAL_W-1:0]    s5_total_ff;
   logic [DAYS_W-1:0]     s5_days_ff;
   logic [HOURS_W-1:0]    s5_hours_ff;
   logic [MINUTES_W-1:0]  s5_min_ff;
   logic [SECONDS_W-1:0]  s5_sec_ff;
   logic                  s5_beat_ff;

   always_comb begin
      logic [HOUR_REM_W-1:0] m_base;
      s5_mprod    = MPW'(s4_rh_ff) * MIN_RECIP;
      s5_min_in   = s5_mprod[MPW-1:MIN_RCP_SHIFT];
      m_base      = HOUR_REM_W'(s5_min_in) * HOUR_REM_W'(MINUTE_S);
      s5_sec_in   = SECONDS_W'(s4_rh_ff - m_base);
      s5_days_ext = DXW'(s4_days_ff);
   end

   always_ff @(posedge clock) begin
      if (s5_rdy && s4_vld_ff) begin
         s5_total_ff <= s4_total_ff;
         s5_days_ff  <= s5_days_ext[DAYS_W-1:0];
         s5_hours_ff <= s4_hours_ff;
         s5_min_ff   <= s5_min_in;
         s5_sec_ff   <= s5_sec_in;
         s5_beat_ff  <= s4_beat_ff;
      end
   end

   assign rsp_if.valid         = s5_vld_ff;
   assign rsp_if.wait_total    = s5_total_ff;
   assign rsp_if.wait_days     = s5_days_ff;
   assign rsp_if.wait_hours    = s5_hours_ff;
   assign rsp_if.wait_minutes  = s5_min_ff;
   assign rsp_if.wait_seconds  = s5_sec_ff;
   assign rsp_if.heartbeat_due = s5_beat_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // both timers sit at or above the floor after any request
   `ASSERT_CLK_RST(a_timer_floor, clock, reset, req_fire |=> (beat_ff >= FLOOR_T && work_ff >= FLOOR_T), "timer below floor after request")
   // a blocked first stage keeps its wait
   `ASSERT_CLK_RST(a_s1_hold, clock, reset, (s1_vld_ff && !s2_rdy) |=> (s1_vld_ff && $stable(s1_wait_ff)), "stage 1 lost its item while blocked")
   // day correction leaves a remainder inside one day
   `ASSERT_CLK_RST(a_day_rem, clock, reset, s3_vld_ff |-> (s3_rd_ff < DAY_REM_W'(DAY_S)), "day remainder out of range")
   // clock fields of a response are in range
   `ASSERT_CLK_RST(a_rsp_range, clock, reset, s5_vld_ff |-> (s5_hours_ff < HOURS_W'(HOURS_PER_DAY) && s5_min_ff < MINUTES_W'(MINUTES_PER_HOUR) && s5_sec_ff < SECONDS_W'(MINUTE_S)), "response time fields out of range")

endmodule
